@@ hw/rtl/sdss_pkg.sv @@
// ----------------------------------------------------------------------------
// sdss_pkg
// Types and constants shared by the spike source bank modules.
// ----------------------------------------------------------------------------
package sdss_pkg;

   localparam logic signed [31:0] ONE_FX    = 32'sd32768;
   localparam int                 DIV_STEPS = 31;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_LOAD   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_ROUTING_KEY    = 3'd0,
      REG_SMP_FLOOR      = 3'd1,
      REG_SMP_SPAN       = 3'd2,
      REG_RECIP_MAX_RATE = 3'd3,
      REG_INPUT_SHIFT    = 3'd4,
      REG_MIN_UPDATE_GAP = 3'd5,
      REG_CUTOFF_TICK    = 3'd6,
      REG_ACTIVE_SOURCES = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic accept_tick;
      logic accept_sample;
      logic accept_load;
      logic div_step;
      logic do_mul;
      logic do_sat;
      logic mem_rd;
      logic proc;
      logic emit_last;
   } cmd_type;

   typedef struct packed {
      logic sample_ok;
      logic n_zero;
      logic div_done;
      logic last_entry;
      logic stall;
      logic flush_ok;
      logic walk_tick;
   } status_type;

   // Signed add clamped to the 32-bit range
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      if (s > 33'sh0_7FFF_FFFF)       sat_add = 32'sh7FFF_FFFF;
      else if (s < -33'sh0_8000_0000) sat_add = 32'sh8000_0000;
      else                            sat_add = s[31:0];
   endfunction

endpackage

@@ hw/rtl/sdss_req_if.sv @@
// ----------------------------------------------------------------------------
// sdss_req_if
// Input item channel: tick, sensor sample or table load.
// ----------------------------------------------------------------------------
interface sdss_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] tick_number;
   logic [31:0] sensor_sample;
   logic [4:0]  entry_index;
   logic [15:0] entry_id;
   logic [31:0] entry_start;
   logic [31:0] entry_end;
   logic signed [31:0] entry_interval;
   logic signed [31:0] entry_countdown;

   modport source (output valid, operation, tick_number, sensor_sample, entry_index,
                   entry_id, entry_start, entry_end, entry_interval, entry_countdown,
                   input ready);
   modport sink (input valid, operation, tick_number, sensor_sample, entry_index,
                 entry_id, entry_start, entry_end, entry_interval, entry_countdown,
                 output ready);
endinterface

@@ hw/rtl/sdss_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sdss_rsp_if
// Result item channel: one spike per item.
// ----------------------------------------------------------------------------
interface sdss_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] routed_key;
   logic [15:0] spike_id;
   logic        last_spike;

   modport source (output valid, routed_key, spike_id, last_spike, input ready);
   modport sink (input valid, routed_key, spike_id, last_spike, output ready);
endinterface

@@ hw/rtl/sdss_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdss_ctrl
// Sequencer: item intake, divide, multiply, table walk and final spike.
// ----------------------------------------------------------------------------
module sdss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [1:0]           in_op,
   output logic                 in_ready,
   output sdss_pkg::cmd_type    cmd,
   input  sdss_pkg::status_type status
);
   import sdss_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_DIV   = 7'b0000010,
      S_MUL   = 7'b0000100,
      S_SAT   = 7'b0001000,
      S_RD    = 7'b0010000,
      S_PROC  = 7'b0100000,
      S_FLUSH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   op_type    op;

   assign op       = op_type'(in_op);
   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               unique case (op)
                  OP_TICK: begin
                     cmd.accept_tick = 1'b1;
                     if (!status.n_zero) state_in = S_RD;
                  end
                  OP_SAMPLE: begin
                     if (status.sample_ok) begin
                        cmd.accept_sample = 1'b1;
                        state_in          = S_DIV;
                     end
                  end
                  OP_LOAD: cmd.accept_load = 1'b1;
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = S_SAT;
         end
         S_SAT: begin
            cmd.do_sat = 1'b1;
            state_in   = status.n_zero ? S_IDLE : S_RD;
         end
         S_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_PROC;
         end
         S_PROC: begin
            cmd.proc = 1'b1;
            if (!status.stall) begin
               if (status.last_entry) state_in = status.walk_tick ? S_FLUSH : S_IDLE;
               else                   state_in = S_RD;
            end
         end
         S_FLUSH: begin
            cmd.emit_last = 1'b1;
            if (status.flush_ok) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROC && status.stall) |=> (state_ff == S_PROC))
      else $error("walk left a stalled entry");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH && !status.flush_ok) |=> (state_ff == S_FLUSH))
      else $error("final spike dropped");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |=> (state_ff == S_PROC))
      else $error("read not followed by process");
endmodule

@@ hw/rtl/sdss_dp.sv @@
// ----------------------------------------------------------------------------
// sdss_dp
// Datapath: registers, source table, serial divider, multiplier, spike staging.
// ----------------------------------------------------------------------------
module sdss_dp #(
   parameter int NUM_SOURCES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  logic [31:0]          in_tick,
   input  logic [31:0]          in_sample,
   input  logic [4:0]           in_index,
   input  logic [15:0]          in_id,
   input  logic [31:0]          in_start,
   input  logic [31:0]          in_end,
   input  logic signed [31:0]   in_interval,
   input  logic signed [31:0]   in_countdown,
   input  sdss_pkg::cmd_type    cmd,
   output sdss_pkg::status_type status,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [31:0]          out_key,
   output logic [15:0]          out_id,
   output logic                 out_last
);
   import sdss_pkg::*;

   localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam int PTR_W = $clog2(NUM_SOURCES + 1);
   localparam logic [6:0] NUM7 = 7'(NUM_SOURCES);

   // configuration
   logic [31:0]        routing_key_ff;
   logic signed [15:0] smp_floor_ff;
   logic [15:0]        smp_span_ff;
   logic signed [31:0] recip_ff;
   logic [4:0]         shift_ff;
   logic [9:0]         gap_ff;
   logic [31:0]        cutoff_ff;
   logic [5:0]         active_ff;

   // scalar state
   logic [31:0] cur_tick_ff, last_upd_ff, tick_ff;
   logic        enabled_ff, walk_tick_ff;
   logic [31:0] e0_start_ff, e0_end_ff;

   // table: static part {id,start,end}, dynamic part {interval,countdown}
   logic [79:0] stat_mem [NUM_SOURCES];
   logic [63:0] dyn_mem  [NUM_SOURCES];
   logic [79:0] stat_rd_ff;
   logic [63:0] dyn_rd_ff;

   // divider and product
   logic [31:0]        den_ff, rem_ff;
   logic [30:0]        qsh_ff;
   logic [4:0]         div_cnt_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] val_ff;

   // walk and spike staging
   logic [PTR_W-1:0] ptr_ff;
   logic             pend_v_ff;
   logic [15:0]      pend_id_ff;
   logic             out_v_ff;
   logic [31:0]      out_key_ff;
   logic [15:0]      out_id_ff;
   logic             out_last_ff;

   logic [6:0]         n_used, act7, idx7, ptr7;
   logic [IDX_W-1:0]   rd_addr, ld_addr;
   logic [31:0]        shifted, den_calc;
   logic [32:0]        trial;
   logic               qbit;
   logic [15:0]        e_id;
   logic [31:0]        e_start, e_end;
   logic signed [31:0] e_int, e_cd, c1, c2, new_cd, new_int;
   logic               e_act, spike, out_free, load_ok;
   logic signed [48:0] fl;

   assign act7    = 7'(active_ff);
   assign n_used  = (act7 > NUM7) ? NUM7 : act7;
   assign idx7    = 7'(in_index);
   assign ptr7    = 7'(ptr_ff);
   assign ld_addr = idx7[IDX_W-1:0];
   assign rd_addr = ptr_ff[IDX_W-1:0];
   assign load_ok = (idx7 < NUM7);

   assign {e_id, e_start, e_end} = stat_rd_ff;
   assign e_int = dyn_rd_ff[63:32];
   assign e_cd  = dyn_rd_ff[31:0];

   assign e_act = (tick_ff >= e_start) && (tick_ff < e_end);
   assign spike = walk_tick_ff && e_act && (e_cd <= 32'sd0);
   assign c1    = spike ? sat_add(e_cd, e_int) : e_cd;
   assign c2    = e_act ? sat_add(c1, -ONE_FX) : c1;

   always_comb begin
      if (walk_tick_ff) begin
         new_int = e_int;
         new_cd  = c2;
      end else begin
         new_int = val_ff;
         new_cd  = (val_ff < e_cd) ? val_ff : e_cd;
      end
   end

   assign out_free = !out_v_ff || out_ready;

   assign shifted  = in_sample >> shift_ff;
   assign den_calc = shifted - 32'(smp_floor_ff) + 32'd1;
   assign trial    = {rem_ff, qsh_ff[30]};
   assign qbit     = (trial >= {1'b0, den_ff});
   assign fl       = 49'(prod_ff >>> 15);

   assign status.sample_ok  = enabled_ff && ((cur_tick_ff - last_upd_ff) >= 32'(gap_ff));
   assign status.n_zero     = (n_used == 7'd0);
   assign status.div_done   = (div_cnt_ff == 5'(DIV_STEPS - 1));
   assign status.last_entry = ((ptr7 + 7'd1) == n_used);
   assign status.stall      = spike && pend_v_ff && !out_free;
   assign status.flush_ok   = !pend_v_ff || out_free;
   assign status.walk_tick  = walk_tick_ff;

   assign out_valid = out_v_ff;
   assign out_key   = out_key_ff;
   assign out_id    = out_id_ff;
   assign out_last  = out_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         routing_key_ff <= '0;
         smp_floor_ff   <= -16'sd256;
         smp_span_ff    <= 16'd1700;
         recip_ff       <= '0;
         shift_ff       <= '0;
         gap_ff         <= 10'd10;
         cutoff_ff      <= '0;
         active_ff      <= '0;
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_index))
            REG_ROUTING_KEY:    routing_key_ff <= csr_wdata;
            REG_SMP_FLOOR:      smp_floor_ff   <= csr_wdata[15:0];
            REG_SMP_SPAN:       smp_span_ff    <= csr_wdata[15:0];
            REG_RECIP_MAX_RATE: recip_ff       <= csr_wdata;
            REG_INPUT_SHIFT:    shift_ff       <= csr_wdata[4:0];
            REG_MIN_UPDATE_GAP: gap_ff         <= csr_wdata[9:0];
            REG_CUTOFF_TICK:    cutoff_ff      <= csr_wdata;
            REG_ACTIVE_SOURCES: active_ff      <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // scalar control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_tick_ff  <= '0;
         last_upd_ff  <= '0;
         enabled_ff   <= 1'b0;
         walk_tick_ff <= 1'b0;
         ptr_ff       <= '0;
         div_cnt_ff   <= '0;
         pend_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         // output register: loaded from staging, else emptied when taken
         if (cmd.proc && !status.stall && spike && pend_v_ff)  out_v_ff <= 1'b1;
         else if (cmd.emit_last && pend_v_ff && out_free)     out_v_ff <= 1'b1;
         else if (out_ready)                                  out_v_ff <= 1'b0;
         if (cmd.accept_tick) begin
            cur_tick_ff  <= in_tick;
            walk_tick_ff <= 1'b1;
            ptr_ff       <= '0;
            // disable test first, enable test second
            if (in_tick > e0_end_ff - 32'd1)        enabled_ff <= 1'b0;
            else if (in_tick == e0_start_ff + 32'd1) enabled_ff <= 1'b1;
         end
         if (cmd.accept_sample) begin
            walk_tick_ff <= 1'b0;
            ptr_ff       <= '0;
            div_cnt_ff   <= '0;
            last_upd_ff  <= cur_tick_ff;
            if (cur_tick_ff > cutoff_ff) enabled_ff <= 1'b0;
         end
         if (cmd.div_step) div_cnt_ff <= div_cnt_ff + 5'd1;
         if (cmd.proc && !status.stall) begin
            ptr_ff <= ptr_ff + PTR_W'(1);
            if (spike) pend_v_ff <= 1'b1;
         end
         if (cmd.emit_last && pend_v_ff && out_free) pend_v_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept_tick) tick_ff <= in_tick;
      if (cmd.accept_load && idx7 == 7'd0) begin
         e0_start_ff <= in_start;
         e0_end_ff   <= in_end;
      end
      if (cmd.accept_sample) begin
         den_ff <= den_calc;
         rem_ff <= '0;
         qsh_ff <= {smp_span_ff, 15'd0};
      end
      if (cmd.div_step) begin
         rem_ff <= qbit ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
         qsh_ff <= {qsh_ff[29:0], qbit};
      end
      if (cmd.do_mul) prod_ff <= $signed({1'b0, qsh_ff}) * recip_ff;
      if (cmd.do_sat) begin
         if (fl > 49'sh0_7FFF_FFFF)       val_ff <= 32'sh7FFF_FFFF;
         else if (fl < -49'sh0_8000_0000) val_ff <= 32'sh8000_0000;
         else                             val_ff <= fl[31:0];
      end
      if (cmd.proc && !status.stall && spike) begin
         pend_id_ff <= e_id;
         if (pend_v_ff) begin
            out_key_ff  <= routing_key_ff | 32'(pend_id_ff);
            out_id_ff   <= pend_id_ff;
            out_last_ff <= 1'b0;
         end
      end
      if (cmd.emit_last && pend_v_ff && out_free) begin
         out_key_ff  <= routing_key_ff | 32'(pend_id_ff);
         out_id_ff   <= pend_id_ff;
         out_last_ff <= 1'b1;
      end
   end

   // source table
   always_ff @(posedge clock) begin
      if (cmd.accept_load && load_ok) begin
         stat_mem[ld_addr] <= {in_id, in_start, in_end};
      end
      if (cmd.mem_rd) stat_rd_ff <= stat_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_load && load_ok) begin
         dyn_mem[ld_addr] <= {in_interval, in_countdown};
      end else if (cmd.proc && !status.stall) begin
         dyn_mem[rd_addr] <= {new_int, new_cd};
      end
      if (cmd.mem_rd) dyn_rd_ff <= dyn_mem[rd_addr];
   end

   assert property (@(posedge clock) disable iff (reset)
      ptr7 <= n_used || !(cmd.mem_rd || cmd.proc))
      else $error("walk pointer beyond used entries");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.proc && status.stall) |=> (ptr_ff == $past(ptr_ff) && pend_v_ff))
      else $error("stalled entry advanced");
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (div_cnt_ff < 5'(DIV_STEPS)))
      else $error("divider overran");
endmodule

@@ hw/rtl/sensor_driven_spike_source_bank.sv @@
// Sequence: a load is taken while idle; a tick is taken, then each used table entry is read
// and then processed, and a final pending spike, if any, is sent; a sensor sample is taken,
// then 31 divider steps, multiply and saturate, then each used entry is read and processed.
// One item at a time; each entry gets one read and one write-back. Spikes stall the walk
// while held. Reset is synchronous, active high: control and configuration registers take
// their reset values; payload registers and the table are undefined until written.
// ----------------------------------------------------------------------------
// sensor_driven_spike_source_bank
// Rate-coded spike source table with sensor-driven interval updates.
// ----------------------------------------------------------------------------
module sensor_driven_spike_source_bank #(
   parameter int NUM_SOURCES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   sdss_req_if.sink    req_if,
   sdss_rsp_if.source  rsp_if
);
   import sdss_pkg::*;

   cmd_type    cmd;
   status_type status;

   sdss_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_op    (req_if.operation),
      .in_ready (req_if.ready),
      .cmd      (cmd),
      .status   (status)
   );

   sdss_dp #(.NUM_SOURCES(NUM_SOURCES)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_tick      (req_if.tick_number),
      .in_sample    (req_if.sensor_sample),
      .in_index     (req_if.entry_index),
      .in_id        (req_if.entry_id),
      .in_start     (req_if.entry_start),
      .in_end       (req_if.entry_end),
      .in_interval  (req_if.entry_interval),
      .in_countdown (req_if.entry_countdown),
      .cmd          (cmd),
      .status       (status),
      .out_valid    (rsp_if.valid),
      .out_ready    (rsp_if.ready),
      .out_key      (rsp_if.routed_key),
      .out_id       (rsp_if.spike_id),
      .out_last     (rsp_if.last_spike)
   );
endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives ticks, sensor samples and table loads into the spike source bank.
// Every spike is checked against a cycle-free model of the table, through
// several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module testbench;
   import sdss_pkg::*;

   typedef struct {
      op_type      op;
      logic [31:0] tick;
      logic [31:0] sample;
      logic [4:0]  index;
      logic [15:0] id;
      logic [31:0] start;
      logic [31:0] stop;
      logic [31:0] interval;
      logic [31:0] countdown;
   } req_item;

   typedef struct {
      logic [31:0] key;
      logic [15:0] id;
      logic        last;
   } spike_item;

   class spike_scoreboard;
      logic [31:0]        routing_key;
      logic signed [15:0] smp_floor;
      logic [15:0]        smp_span;
      logic signed [31:0] recip_rate;
      logic [4:0]         input_shift;
      logic [9:0]         update_gap;
      logic [31:0]        cutoff;
      logic [5:0]         used_sources;
      logic [15:0]        src_id       [32];
      logic [31:0]        src_start    [32];
      logic [31:0]        src_stop     [32];
      logic signed [31:0] src_interval [32];
      logic signed [31:0] src_count    [32];
      logic [31:0]        cur_tick;
      logic [31:0]        last_update;
      logic               sensor_on;
      spike_item          pending_spikes[$];
      int                 errors;
      int                 spikes_seen;
      int                 updates_taken;

      function new();
         routing_key  = '0;
         smp_floor    = -16'sd256;
         smp_span     = 16'd1700;
         recip_rate   = '0;
         input_shift  = '0;
         update_gap   = 10'd10;
         cutoff       = '0;
         used_sources = '0;
         cur_tick     = '0;
         last_update  = '0;
         sensor_on    = 1'b0;
         errors = 0;
         spikes_seen = 0;
         updates_taken = 0;
         for (int i = 0; i < 32; i++) begin
            src_id[i] = '0; src_start[i] = '0; src_stop[i] = '0;
            src_interval[i] = '0; src_count[i] = '0;
         end
      endfunction

      function logic signed [31:0] clamp(input logic signed [63:0] v);
         if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
         if (v < -64'sh8000_0000) return 32'sh8000_0000;
         return v[31:0];
      endfunction

      function void write_reg(input reg_idx_type idx, input logic [31:0] data);
         case (idx)
            REG_ROUTING_KEY:    routing_key  = data;
            REG_SMP_FLOOR:      smp_floor    = data[15:0];
            REG_SMP_SPAN:       smp_span     = data[15:0];
            REG_RECIP_MAX_RATE: recip_rate   = data;
            REG_INPUT_SHIFT:    input_shift  = data[4:0];
            REG_MIN_UPDATE_GAP: update_gap   = data[9:0];
            REG_CUTOFF_TICK:    cutoff       = data;
            REG_ACTIVE_SOURCES: used_sources = data[5:0];
            default: ;
         endcase
      endfunction

      // span * 2^15 / (shifted - floor + 1) * rate, floored and clamped
      function logic signed [31:0] sensor_interval(input logic [31:0] sample);
         logic [31:0]        shifted;
         logic [31:0]        den;
         logic signed [63:0] quot;
         logic signed [63:0] prod;
         shifted = sample >> input_shift;
         den = shifted - {{16{smp_floor[15]}}, smp_floor} + 32'd1;
         if (den == 0) quot = 64'sh7FFF_FFFF;
         else quot = $signed({17'd0, smp_span, 31'd0} >> 16) / $signed({32'd0, den});
         prod = quot * $signed({{32{recip_rate[31]}}, recip_rate});
         return clamp(prod >>> 15);
      endfunction

      function void note_item(input req_item it);
         int          n;
         int          first;
         logic signed [31:0] val;
         n = (used_sources > 32) ? 32 : used_sources;
         first = pending_spikes.size();
         case (it.op)
            OP_TICK: begin
               if (it.tick == src_start[0] + 32'd1) sensor_on = 1'b1;
               if (it.tick > src_stop[0] - 32'd1) sensor_on = 1'b0;
               cur_tick = it.tick;
               for (int i = 0; i < n; i++) begin
                  if (it.tick >= src_start[i] && it.tick < src_stop[i]) begin
                     if (src_count[i] <= 0) begin
                        pending_spikes.push_back('{routing_key | {16'd0, src_id[i]},
                                                   src_id[i], 1'b0});
                        src_count[i] = clamp(64'(src_count[i]) + 64'(src_interval[i]));
                     end
                     src_count[i] = clamp(64'(src_count[i]) - 64'(ONE_FX));
                  end
               end
               if (pending_spikes.size() > first)
                  pending_spikes[pending_spikes.size() - 1].last = 1'b1;
            end
            OP_SAMPLE: begin
               if (sensor_on && (cur_tick - last_update) >= {22'd0, update_gap}) begin
                  val = sensor_interval(it.sample);
                  for (int i = 0; i < n; i++) begin
                     if (val < src_count[i]) src_count[i] = val;
                     src_interval[i] = val;
                  end
                  last_update = cur_tick;
                  updates_taken++;
                  if (cur_tick > cutoff) sensor_on = 1'b0;
               end
            end
            OP_LOAD: begin
               src_id[it.index]       = it.id;
               src_start[it.index]    = it.start;
               src_stop[it.index]     = it.stop;
               src_interval[it.index] = it.interval;
               src_count[it.index]    = it.countdown;
            end
            default: ;
         endcase
      endfunction

      function void check_spike(input logic [31:0] key, input logic [15:0] id,
                                input logic last);
         spike_item exp_s;
         spikes_seen++;
         if (pending_spikes.size() == 0) begin
            $error("unexpected spike: key %h id %h last %b", key, id, last);
            errors++;
            return;
         end
         exp_s = pending_spikes.pop_front();
         if (key !== exp_s.key) begin
            $error("routed_key: expected %h, got %h", exp_s.key, key);
            errors++;
         end
         if (id !== exp_s.id) begin
            $error("spike_id: expected %h, got %h", exp_s.id, id);
            errors++;
         end
         if (last !== exp_s.last) begin
            $error("last_spike: expected %b, got %b", exp_s.last, last);
            errors++;
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE      = 150;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   sdss_req_if req_if ();
   sdss_rsp_if rsp_if ();

   sensor_driven_spike_source_bank i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source)
   );

   spike_scoreboard spike_sb;
   int          idle_pct;
   int          stall_pct;
   bit          long_hold;
   int          hold_left;
   int          quiet_cycles;
   int          items_sent;
   logic [31:0] next_tick;

   initial begin
      clock = 1'b0;
   end
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready = 1'b0;
      end else if (long_hold) begin
         long_hold = 1'b0;
         hold_left = 400;
         rsp_if.ready = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready = 1'b0;
      end else begin
         rsp_if.ready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (req_if.valid && req_if.ready) begin
            spike_sb.note_item('{op_type'(req_if.operation), req_if.tick_number,
                                 req_if.sensor_sample, req_if.entry_index,
                                 req_if.entry_id, req_if.entry_start, req_if.entry_end,
                                 req_if.entry_interval, req_if.entry_countdown});
            quiet_cycles = 0;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            spike_sb.check_spike(rsp_if.routed_key, rsp_if.spike_id, rsp_if.last_spike);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send_item(input req_item it);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid           = 1'b1;
      req_if.operation       = it.op;
      req_if.tick_number     = it.tick;
      req_if.sensor_sample   = it.sample;
      req_if.entry_index     = it.index;
      req_if.entry_id        = it.id;
      req_if.entry_start     = it.start;
      req_if.entry_end       = it.stop;
      req_if.entry_interval  = it.interval;
      req_if.entry_countdown = it.countdown;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid = 1'b0;
      while (spike_sb.pending_spikes.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input reg_idx_type idx, input logic [31:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      spike_sb.write_reg(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_all(input logic [31:0] key, input logic [15:0] floor_v,
                            input logic [15:0] span_v, input logic [31:0] rate,
                            input logic [4:0] shift, input logic [9:0] gap,
                            input logic [31:0] cut, input logic [5:0] used);
      write_csr(REG_ROUTING_KEY, key);
      write_csr(REG_SMP_FLOOR, {16'd0, floor_v});
      write_csr(REG_SMP_SPAN, {16'd0, span_v});
      write_csr(REG_RECIP_MAX_RATE, rate);
      write_csr(REG_INPUT_SHIFT, {27'd0, shift});
      write_csr(REG_MIN_UPDATE_GAP, {22'd0, gap});
      write_csr(REG_CUTOFF_TICK, cut);
      write_csr(REG_ACTIVE_SOURCES, {26'd0, used});
   endtask

   function automatic req_item tick_item(input logic [31:0] t);
      req_item it;
      it = '{OP_TICK, t, $urandom, 5'($urandom), 16'($urandom), $urandom, $urandom,
             $urandom, $urandom};
      return it;
   endfunction

   function automatic req_item load_item(input logic [4:0] idx, input bit wild);
      req_item it;
      it = tick_item($urandom);
      it.op    = OP_LOAD;
      it.index = idx;
      if (wild) return it;
      it.start     = next_tick - $urandom_range(0, 20);
      it.stop      = it.start + $urandom_range(30, 400);
      it.interval  = $urandom_range(0, 6 * 32768);
      it.countdown = $signed($urandom_range(0, 8 * 32768)) - 32'sd32768;
      return it;
   endfunction

   // mostly advancing ticks, some samples and reloads, a little noise
   function automatic req_item random_item();
      int      pick;
      req_item it;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         next_tick = ($urandom_range(0, 19) == 0) ? $urandom
                                                   : next_tick + $urandom_range(1, 3);
         it = tick_item(next_tick);
      end else if (pick < 85) begin
         it = tick_item(next_tick);
         it.op = OP_SAMPLE;
      end else if (pick < 97) begin
         it = load_item(5'($urandom), $urandom_range(0, 7) == 0);
      end else begin
         it = tick_item($urandom);
         it.op = OP_NONE;
      end
      return it;
   endfunction

   initial begin
      req_item it;
      spike_sb = new();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.operation = OP_TICK;
      req_if.tick_number = '0;
      req_if.sensor_sample = '0;
      req_if.entry_index = '0;
      req_if.entry_id = '0;
      req_if.entry_start = '0;
      req_if.entry_end = '0;
      req_if.entry_interval = '0;
      req_if.entry_countdown = '0;
      idle_pct = 0;
      stall_pct = 0;
      long_hold = 1'b0;
      hold_left = 0;
      quiet_cycles = 0;
      items_sent = 0;
      next_tick = 32'd100;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_all(32'h0001_0000, 16'hFF00, 16'd1700, 32'sd32768, 5'd0, 10'd0,
                32'hFFFF_FFFF, 6'd32);
      // fill every slot first; entry 0 sets the sensor window
      for (int i = 0; i < 32; i++) begin
         it = load_item(5'(i), 0);
         if (i == 0) begin
            it.start = 32'd100; it.stop = 32'd200;
         end
         send_item(it);
      end
      it = load_item(5'd1, 0);
      it.id = 16'hFFFF; it.start = 32'd0; it.stop = 32'hFFFF_FFFF;
      it.interval = 32'h7FFF_FFFF; it.countdown = 32'h8000_0000;
      send_item(it);
      it = load_item(5'd31, 0);
      it.id = 16'h0000; it.interval = 32'h8000_0000; it.countdown = 32'd0;
      send_item(it);
      send_item(tick_item(32'd100));
      send_item(tick_item(32'd101));     // opens sensor input
      it = tick_item(32'd101); it.op = OP_SAMPLE; it.sample = 32'd0;
      send_item(it);
      it.sample = 32'hFFFF_FFFF;
      send_item(it);
      for (int t = 102; t < 110; t++) send_item(tick_item(32'(t)));
      it = tick_item($urandom); it.op = OP_NONE;
      send_item(it);
      send_item(tick_item(32'd0));
      send_item(tick_item(32'hFFFF_FFFF));   // past entry 0 end: input closed
      it = tick_item(32'd0); it.op = OP_SAMPLE;
      send_item(it);
      drain();
      write_csr(REG_ACTIVE_SOURCES, 32'd0);
      send_item(tick_item(32'd150));
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               idle_pct = 0; stall_pct = 0;
               write_all(32'h8000_0000, 16'hFF00, 16'd1700, 32'sd32768, 5'd0, 10'd0,
                         32'hFFFF_FFFF, 6'd32);
            end
            1: begin
               idle_pct = 88; stall_pct = 0;
               write_all(32'hFFFF_FFFF, 16'h8001, 16'd65534, 32'h7FFF_FFFF, 5'd31,
                         10'd1023, 32'd0, 6'd63);
            end
            2: begin
               idle_pct = 0; stall_pct = 88;
               write_all(32'd0, 16'h7FFF, 16'd0, 32'h8000_0000, 5'd4, 10'd1,
                         32'd500, 6'd1);
            end
            default: begin
               idle_pct = 25; stall_pct = 25;
               write_all(32'h1234_0000, 16'd0, 16'd300, 32'sd16384, 5'd8, 10'd3,
                         32'hFFFF_FFFF, 6'd17);
            end
         endcase
         // reopen the sensor window around the current tick
         it = load_item(5'd0, 0);
         it.start = next_tick; it.stop = next_tick + 32'd1000;
         send_item(it);
         next_tick = next_tick + 32'd1;
         send_item(tick_item(next_tick));
         for (int k = 0; k < 15; k++) begin
            if (ph == 0 && k == 5) long_hold = 1'b1;
            if (ph == 0 && k == 12) drain();
            send_item(random_item());
         end
         drain();
      end

      $display("covered %0d items, %0d spikes, %0d sensor updates taken",
               items_sent, spike_sb.spikes_seen, spike_sb.updates_taken);
      $display("four idle/stall patterns, register extremes and one long output hold");
      if (spike_sb.errors == 0 && spike_sb.pending_spikes.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
